[sv/ghp_pkg.sv]
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants of the gzip member header parser: request and
// result layouts, action and status codes, parser phases and header bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package ghp_pkg;

	// header constants
	localparam logic [7:0] MAGIC_ID1     = 8'h1f;
	localparam logic [7:0] MAGIC_ID2     = 8'h8b;
	localparam logic [7:0] METHOD_DEFL   = 8'h08;
	localparam logic [7:0] FLG_RESERVED  = 8'he0;
	localparam int unsigned FLG_FHCRC    = 1;
	localparam int unsigned FLG_FEXTRA   = 2;
	localparam int unsigned FLG_FNAME    = 3;
	localparam int unsigned FLG_FCOMMENT = 4;
	localparam logic [15:0] FIXED_SKIP   = 16'd6;
	localparam logic [15:0] HCRC_SKIP    = 16'd2;

	typedef enum logic [1:0] {
		ACT_DATA    = 2'd0,
		ACT_END     = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_DONE    = 3'd1,
		ST_PAYLOAD = 3'd2,
		ST_ERROR   = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_END     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_METHOD  = 4'd2,
		PH_FLAGS   = 4'd3,
		PH_FIXED   = 4'd4,
		PH_XLEN_LO = 4'd5,
		PH_XLEN_HI = 4'd6,
		PH_EXTRA   = 4'd7,
		PH_NAME    = 4'd8,
		PH_COMMENT = 4'd9,
		PH_HCRC    = 4'd10,
		PH_PAYLOAD = 4'd11,
		PH_RAW     = 4'd12,
		PH_ERROR   = 4'd13,
		PH_ENDED   = 4'd14
	} phase_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload_byte;
		logic       transparent;
		logic [4:0] header_flags;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

[sv/ghp_stream_if.sv]
// ----------------------------------------------------------------------------
// ghp_stream_if
// Valid/ready stream channel carrying one request of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface ghp_stream_if #(
	parameter type payload_t = logic [7:0]
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[sv/ghp_parse_core.sv]
// ----------------------------------------------------------------------------
// ghp_parse_core
// Header parser state machine. Consumes one registered request per fire and
// produces zero, one or two result requests in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_parse_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire ghp_pkg::item_t  item,
	output logic [1:0]           res_cnt,
	output ghp_pkg::result_t     res0,
	output ghp_pkg::result_t     res1
);

	ghp_pkg::phase_t  phase_q, phase_d, np;
	logic [4:0]       flags_q, flags_d;
	logic [15:0]      skip_q, skip_d;
	logic [7:0]       held_q, held_d;
	logic             transp_q, transp_d;
	ghp_pkg::status_t st0, st1;
	logic [7:0]       b0, b1;
	logic             gen;
	logic             cd_done;
	ghp_pkg::phase_t  ac_ph, an_ph, ae_ph, af_ph;
	logic [7:0]       b;

	assign b       = item.data_byte;
	assign cd_done = (skip_q <= 16'd1);

	// optional field chain following each header section
	assign ac_ph = flags_q[ghp_pkg::FLG_FHCRC]    ? ghp_pkg::PH_HCRC    : ghp_pkg::PH_PAYLOAD;
	assign an_ph = flags_q[ghp_pkg::FLG_FCOMMENT] ? ghp_pkg::PH_COMMENT : ac_ph;
	assign ae_ph = flags_q[ghp_pkg::FLG_FNAME]    ? ghp_pkg::PH_NAME    : an_ph;
	assign af_ph = flags_q[ghp_pkg::FLG_FEXTRA]   ? ghp_pkg::PH_XLEN_LO : ae_ph;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ghp_pkg::PH_MAGIC0;
			flags_q  <= '0;
			skip_q   <= '0;
			held_q   <= '0;
			transp_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			flags_q  <= flags_d;
			skip_q   <= skip_d;
			held_q   <= held_d;
			transp_q <= transp_d;
		end
	end

	// next state and results
	always_comb begin
		phase_d  = phase_q;
		flags_d  = flags_q;
		skip_d   = skip_q;
		held_d   = held_q;
		transp_d = transp_q;
		np       = phase_q;
		gen      = 1'b0;
		res_cnt  = 2'd0;
		st0      = ghp_pkg::ST_HEADER;
		st1      = ghp_pkg::ST_END;
		b0       = 8'h00;
		b1       = 8'h00;
		if (fire) begin
			case (item.action)
				ghp_pkg::ACT_DATA: begin
					unique case (phase_q)
						ghp_pkg::PH_MAGIC0: begin
							held_d  = b;
							phase_d = ghp_pkg::PH_MAGIC1;
							res_cnt = 2'd1;
						end
						ghp_pkg::PH_MAGIC1: begin
							if (held_q == ghp_pkg::MAGIC_ID1 && b == ghp_pkg::MAGIC_ID2) begin
								phase_d = ghp_pkg::PH_METHOD;
								res_cnt = 2'd1;
							end else begin
								// not gzip: release the held byte, then this one
								transp_d = 1'b1;
								phase_d  = ghp_pkg::PH_RAW;
								res_cnt  = 2'd2;
								st0      = ghp_pkg::ST_PAYLOAD;
								b0       = held_q;
								st1      = ghp_pkg::ST_PAYLOAD;
								b1       = b;
							end
						end
						ghp_pkg::PH_METHOD: begin
							gen = 1'b1;
							np  = (b == ghp_pkg::METHOD_DEFL) ? ghp_pkg::PH_FLAGS
							                                  : ghp_pkg::PH_ERROR;
						end
						ghp_pkg::PH_FLAGS: begin
							gen     = 1'b1;
							flags_d = b[4:0];
							if ((b & ghp_pkg::FLG_RESERVED) != 8'h00) begin
								np = ghp_pkg::PH_ERROR;
							end else begin
								skip_d = ghp_pkg::FIXED_SKIP;
								np     = ghp_pkg::PH_FIXED;
							end
						end
						ghp_pkg::PH_FIXED: begin
							gen = 1'b1;
							if (cd_done) begin
								skip_d = '0;
								np     = af_ph;
							end else begin
								skip_d = skip_q - 16'd1;
							end
						end
						ghp_pkg::PH_XLEN_LO: begin
							gen    = 1'b1;
							skip_d = {8'h00, b};
							np     = ghp_pkg::PH_XLEN_HI;
						end
						ghp_pkg::PH_XLEN_HI: begin
							gen    = 1'b1;
							skip_d = {b, skip_q[7:0]};
							np     = ({b, skip_q[7:0]} == 16'd0) ? ae_ph : ghp_pkg::PH_EXTRA;
						end
						ghp_pkg::PH_EXTRA: begin
							gen = 1'b1;
							if (cd_done) begin
								skip_d = '0;
								np     = ae_ph;
							end else begin
								skip_d = skip_q - 16'd1;
							end
						end
						ghp_pkg::PH_NAME: begin
							gen = 1'b1;
							if (b == 8'h00) np = an_ph;
						end
						ghp_pkg::PH_COMMENT: begin
							gen = 1'b1;
							if (b == 8'h00) np = ac_ph;
						end
						ghp_pkg::PH_HCRC: begin
							gen = 1'b1;
							if (cd_done) begin
								skip_d = '0;
								np     = ghp_pkg::PH_PAYLOAD;
							end else begin
								skip_d = skip_q - 16'd1;
							end
						end
						ghp_pkg::PH_PAYLOAD, ghp_pkg::PH_RAW: begin
							res_cnt = 2'd1;
							st0     = ghp_pkg::ST_PAYLOAD;
							b0      = b;
						end
						ghp_pkg::PH_ERROR: begin
							res_cnt = 2'd1;
							st0     = ghp_pkg::ST_ERROR;
						end
						default: begin
							phase_d = ghp_pkg::PH_ENDED;
							res_cnt = 2'd1;
							st0     = ghp_pkg::ST_END;
						end
					endcase
					// common result for header walking phases
					if (gen) begin
						phase_d = np;
						res_cnt = 2'd1;
						if (np == ghp_pkg::PH_HCRC && phase_q != ghp_pkg::PH_HCRC)
							skip_d = ghp_pkg::HCRC_SKIP;
						if (np == ghp_pkg::PH_ERROR)
							st0 = ghp_pkg::ST_ERROR;
						else if (np == ghp_pkg::PH_PAYLOAD)
							st0 = ghp_pkg::ST_DONE;
						else
							st0 = ghp_pkg::ST_HEADER;
					end
				end
				ghp_pkg::ACT_END: begin
					unique case (phase_q)
						ghp_pkg::PH_MAGIC0: begin
							phase_d = ghp_pkg::PH_ENDED;
							res_cnt = 2'd1;
							st0     = ghp_pkg::ST_EMPTY;
						end
						ghp_pkg::PH_MAGIC1: begin
							// a lone byte passes through raw
							transp_d = 1'b1;
							phase_d  = ghp_pkg::PH_ENDED;
							res_cnt  = 2'd2;
							st0      = ghp_pkg::ST_PAYLOAD;
							b0       = held_q;
							st1      = ghp_pkg::ST_END;
						end
						ghp_pkg::PH_PAYLOAD, ghp_pkg::PH_RAW, ghp_pkg::PH_ENDED: begin
							phase_d = ghp_pkg::PH_ENDED;
							res_cnt = 2'd1;
							st0     = ghp_pkg::ST_END;
						end
						default: begin
							// end inside the header is a sticky error
							phase_d = ghp_pkg::PH_ERROR;
							res_cnt = 2'd1;
							st0     = ghp_pkg::ST_ERROR;
						end
					endcase
				end
				ghp_pkg::ACT_RESTART: begin
					if (phase_q != ghp_pkg::PH_ERROR) begin
						phase_d  = ghp_pkg::PH_MAGIC0;
						flags_d  = '0;
						skip_d   = '0;
						held_d   = '0;
						transp_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result packing with the updated flags and transparency
	always_comb begin
		res0.status       = st0;
		res0.payload_byte = b0;
		res0.transparent  = transp_d;
		res0.header_flags = flags_d;
		res0.last         = (res_cnt == 2'd1);
		res1.status       = st1;
		res1.payload_byte = b1;
		res1.transparent  = transp_d;
		res1.header_flags = flags_d;
		res1.last         = 1'b1;
	end

endmodule

`default_nettype wire

[sv/ghp_result_fifo.sv]
// ----------------------------------------------------------------------------
// ghp_result_fifo
// Four-entry result queue. Takes up to two results per cycle from the parser
// and hands them out one per cycle on a valid/ready channel while ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_result_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_cnt,
	input  wire ghp_pkg::result_t  push0,
	input  wire ghp_pkg::result_t  push1,
	output logic                   room,
	output logic [2:0]             level,
	ghp_stream_if.source           result_ch
);

	ghp_pkg::result_t mem_q [4];
	logic [1:0]       wr_ptr_q, rd_ptr_q;
	logic [2:0]       cnt_q;
	logic             pop;

	assign pop             = result_ch.valid && result_ch.ready;
	assign result_ch.valid = (cnt_q != 3'd0);
	assign result_ch.payload = mem_q[rd_ptr_q];
	assign level           = cnt_q;

	// space for two results after this cycle's pop
	assign room = (cnt_q <= 3'd2) || (cnt_q == 3'd3 && pop);

	// entry storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			cnt_q    <= cnt_q + {1'b0, push_cnt} - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

[sv/gzip_header_parser_top.sv]
// ----------------------------------------------------------------------------
// gzip_header_parser_top
// Byte-stream gzip member header parser with pass-through of the payload.
//
// Usage:
//   byte_ch carries one request per accepted beat: an action (data byte, end
//   of input, restart) and a data byte. result_ch returns the results each
//   request causes, zero to two, the final one of a request marked last.
//   A request is registered on acceptance, decoded by the parser once the
//   queue has room and written to a four-entry result queue, from which its
//   results are offered on result_ch. One request is taken every cycle while
//   the queue has room; a request with two results holds two queue slots and
//   is handed out as two results on result_ch.
//   The input register drains into the parser only while the queue has two
//   free slots, so a stalled receiver fills the queue and then byte_ch
//   drops ready; nothing is lost or repeated.
//   Reset clears the parser to expect the first magic byte, with flags,
//   counts, held byte and transparency cleared, and empties the queue.
//   A data error stays until reset; restart does not clear it.
// ----------------------------------------------------------------------------
`default_nettype none

module gzip_header_parser_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ghp_stream_if.sink    byte_ch,
	ghp_stream_if.source  result_ch
);

	ghp_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             advance;
	logic             room;
	logic [2:0]       level;
	logic [1:0]       res_cnt;
	ghp_pkg::result_t res0, res1;

	assign advance       = valid_s1 && room;
	assign byte_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) item_s1 <= byte_ch.payload;
	end

	ghp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.item    (item_s1),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	ghp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (res_cnt),
		.push0     (res0),
		.push1     (res1),
		.room      (room),
		.level     (level),
		.result_ch (result_ch)
	);

	// queue never overflows
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("result queue over capacity");

	// errors only arise while walking a gzip header
	a_error_not_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.payload.status == ghp_pkg::ST_ERROR)
		|-> !result_ch.payload.transparent)
		else $error("data error on a transparent stream");

	// raw streams never read a flag byte
	a_raw_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.payload.transparent)
		|-> (result_ch.payload.header_flags == 5'd0))
		else $error("flags set on a transparent stream");

	// only payload results carry a byte
	a_byte_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.payload.status != ghp_pkg::ST_PAYLOAD)
		|-> (result_ch.payload.payload_byte == 8'h00))
		else $error("byte on a non-payload result");

endmodule

`default_nettype wire
